FILE: rtl/stl_pkg.sv
// Shared types, constants and byte classification for the SQL token lexer.
package stl_pkg;

	localparam int POS_W = 20;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [2:0] KIND_COMMENT = 3'd0;
	localparam logic [2:0] KIND_LITERAL = 3'd1;
	localparam logic [2:0] KIND_WORD    = 3'd2;
	localparam logic [2:0] KIND_QIDENT  = 3'd3;
	localparam logic [2:0] KIND_OPER    = 3'd4;
	localparam logic [2:0] KIND_PUNCT   = 3'd5;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic       space;
		logic       digit;
		logic       ident_start;
		logic       ident_part;
		logic       lookahead;
		logic       single_ok;
		logic [2:0] single_kind;
	} cls_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       eot;
		pos_t       pos;
		logic       ovf;
		cls_t       cls;
	} entry_t;

	typedef struct packed {
		logic [2:0] kind;
		pos_t       start;
		pos_t       len;
	} tok_t;

	// Kind of a one-byte operator or punctuation token; ok is low for bytes dropped.
	function automatic logic [3:0] single_tok(input logic [7:0] b);
		logic [3:0] r;
		r = {1'b0, KIND_COMMENT};
		case (b)
			"+", "-", "*", "/", "%", "=", "<", ">", "~", "!", "&", "|", "^", "#":
				r = {1'b1, KIND_OPER};
			"(", ")", ",", ";", ".", "[", "]", "{", "}":
				r = {1'b1, KIND_PUNCT};
			default: r = {1'b0, KIND_COMMENT};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/stl_front.sv
// Input side: byte classification and text position tracking.
module stl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      char_byte,
	input  logic            end_of_text,
	input  logic            qfull,
	output logic            wr_en,
	output stl_pkg::entry_t wr_data
);

	stl_pkg::pos_t pos_q;
	logic          ovf_q;
	logic [3:0]    st;
	logic          alpha;
	logic          digit;

	assign wr_en = push && !qfull;
	assign st    = stl_pkg::single_tok(char_byte);
	assign alpha = (char_byte >= "a" && char_byte <= "z") ||
	               (char_byte >= "A" && char_byte <= "Z");
	assign digit = char_byte >= "0" && char_byte <= "9";

	always_comb begin
		wr_data.chr                 = char_byte;
		wr_data.eot                 = end_of_text;
		wr_data.pos                 = pos_q;
		wr_data.ovf                 = ovf_q;
		wr_data.cls.space           = char_byte == " " ||
		                              (char_byte >= 8'd9 && char_byte <= 8'd13);
		wr_data.cls.digit           = digit;
		wr_data.cls.ident_start     = alpha || char_byte == "_";
		wr_data.cls.ident_part      = alpha || digit || char_byte == "_";
		wr_data.cls.lookahead       = char_byte == "-" || char_byte == "/" ||
		                              char_byte == "." || char_byte == "<" ||
		                              char_byte == ">" || char_byte == "!" ||
		                              char_byte == "|" || char_byte == "=" ||
		                              char_byte == ":";
		wr_data.cls.single_ok       = st[3];
		wr_data.cls.single_kind     = st[2:0];
	end

	// Saturate the position within a text, restart it after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (wr_en) begin
			if (end_of_text) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else if (pos_q == stl_pkg::POS_MAX) begin
				ovf_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/stl_fifo.sv
// Short queue of classified bytes between the input and token sides.
module stl_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  stl_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output stl_pkg::entry_t rd_data,
	output logic            empty
);

	stl_pkg::entry_t            mem_q [stl_pkg::QDEPTH];
	logic [stl_pkg::QAW-1:0]    wptr_q;
	logic [stl_pkg::QAW-1:0]    rptr_q;
	logic [stl_pkg::QAW:0]      cnt_q;

	assign full    = cnt_q == (stl_pkg::QAW+1)'(stl_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/stl_back.sv
// Token side: lexer state machine and result delivery.
module stl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  stl_pkg::entry_t ent,
	input  logic            qempty,
	output logic            qpop,
	output logic            empty,
	input  logic            pop,
	output logic [2:0]      token_kind,
	output logic [19:0]     start_pos,
	output logic [19:0]     token_length,
	output logic            last_of_run,
	output logic            pos_overflow
);

	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_HELD  = 4'd1;
	localparam logic [3:0] M_LINE  = 4'd2;
	localparam logic [3:0] M_BLOCK = 4'd3;
	localparam logic [3:0] M_BSTAR = 4'd4;
	localparam logic [3:0] M_STR   = 4'd5;
	localparam logic [3:0] M_STRQ  = 4'd6;
	localparam logic [3:0] M_QID   = 4'd7;
	localparam logic [3:0] M_NUM   = 4'd8;
	localparam logic [3:0] M_NUME  = 4'd9;
	localparam logic [3:0] M_WORD  = 4'd10;

	logic [3:0]    mode_q;
	stl_pkg::pos_t tb_q;
	logic          dot_q;
	logic [7:0]    held_q;

	stl_pkg::tok_t slot_q [3];
	logic [1:0]    cnt_q;
	logic [1:0]    idx_q;
	logic          ovf_q;

	logic [3:0]    nm;
	stl_pkg::pos_t ntb;
	logic          ndot;
	logic [7:0]    nheld;
	logic          do_start;
	logic          do_num;
	logic [2:0]    rv;
	stl_pkg::tok_t rt   [3];
	stl_pkg::tok_t res  [3];
	logic [1:0]    n;
	logic [3:0]    hs;
	logic [3:0]    ns;
	logic [7:0]    b;
	stl_pkg::pos_t p;
	stl_pkg::tok_t cur;
	logic          last;
	logic          load;

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] c);
		return (a == "<" && (c == "=" || c == ">")) || (a == ">" && c == "=") ||
		       (a == "!" && c == "=") || (a == "|" && c == "|") ||
		       (a == "-" && c == ">") || (a == "=" && c == ">") ||
		       (a == ":" && c == ":");
	endfunction

	function automatic logic [2:0] mode_kind(input logic [3:0] m);
		logic [2:0] k;
		unique case (m)
			M_LINE, M_BLOCK, M_BSTAR: k = stl_pkg::KIND_COMMENT;
			M_WORD:                   k = stl_pkg::KIND_WORD;
			M_QID:                    k = stl_pkg::KIND_QIDENT;
			default:                  k = stl_pkg::KIND_LITERAL;
		endcase
		return k;
	endfunction

	assign b  = ent.chr;
	assign p  = ent.pos;
	assign hs = stl_pkg::single_tok(held_q);

	// Three possible results per byte: the token the byte ends, a one-byte token
	// the byte starts, and the token flushed at end of text.
	always_comb begin
		nm       = mode_q;
		ntb      = tb_q;
		ndot     = dot_q;
		nheld    = held_q;
		do_start = 1'b0;
		do_num   = 1'b0;
		rv       = '0;
		ns       = '0;
		for (int i = 0; i < 3; i++) begin
			rt[i] = '0;
		end

		unique case (mode_q)
			M_HELD: begin
				if (held_q == "-" && b == "-") begin
					nm = M_LINE;
				end else if (held_q == "/" && b == "*") begin
					nm = M_BLOCK;
				end else if (held_q == "." && ent.cls.digit) begin
					nm   = M_NUM;
					ndot = 1'b1;
				end else if (is_pair(held_q, b)) begin
					rv[0] = 1'b1;
					rt[0] = '{stl_pkg::KIND_OPER, tb_q, stl_pkg::pos_t'(2)};
					nm    = M_IDLE;
				end else begin
					rv[0]    = hs[3];
					rt[0]    = '{hs[2:0], tb_q, stl_pkg::pos_t'(1)};
					do_start = 1'b1;
				end
			end
			M_LINE: begin
				if (b == 8'h0A) begin
					rv[0] = 1'b1;
					rt[0] = '{stl_pkg::KIND_COMMENT, tb_q, p - tb_q};
					nm    = M_IDLE;
				end
			end
			M_BLOCK: begin
				if (b == "*") begin
					nm = M_BSTAR;
				end
			end
			M_BSTAR: begin
				if (b == "/") begin
					rv[0] = 1'b1;
					rt[0] = '{stl_pkg::KIND_COMMENT, tb_q, p - tb_q + 1'b1};
					nm    = M_IDLE;
				end else if (b != "*") begin
					nm = M_BLOCK;
				end
			end
			M_STR: begin
				if (b == "'") begin
					nm = M_STRQ;
				end
			end
			M_STRQ: begin
				if (b == "'") begin
					nm = M_STR;
				end else begin
					rv[0]    = 1'b1;
					rt[0]    = '{stl_pkg::KIND_LITERAL, tb_q, p - tb_q};
					do_start = 1'b1;
				end
			end
			M_QID: begin
				if (b == "\"") begin
					rv[0] = 1'b1;
					rt[0] = '{stl_pkg::KIND_QIDENT, tb_q, p - tb_q + 1'b1};
					nm    = M_IDLE;
				end
			end
			M_NUM: do_num = 1'b1;
			M_NUME: begin
				nm     = M_NUM;
				do_num = b != "+" && b != "-";
			end
			M_WORD: begin
				if (!ent.cls.ident_part) begin
					rv[0]    = 1'b1;
					rt[0]    = '{stl_pkg::KIND_WORD, tb_q, p - tb_q};
					do_start = 1'b1;
				end
			end
			default: do_start = 1'b1;
		endcase

		if (do_num) begin
			if (b == "." && !dot_q) begin
				ndot = 1'b1;
			end else if (ent.cls.digit) begin
				nm = nm;
			end else if (b == "e" || b == "E") begin
				nm = M_NUME;
			end else begin
				rv[0]    = 1'b1;
				rt[0]    = '{stl_pkg::KIND_LITERAL, tb_q, p - tb_q};
				do_start = 1'b1;
			end
		end

		if (do_start) begin
			nm = M_IDLE;
			if (!ent.cls.space) begin
				ntb = p;
				if (ent.cls.lookahead) begin
					nm    = M_HELD;
					nheld = b;
				end else if (b == "'") begin
					nm = M_STR;
				end else if (b == "\"") begin
					nm = M_QID;
				end else if (ent.cls.digit) begin
					nm   = M_NUM;
					ndot = 1'b0;
				end else if (ent.cls.ident_start) begin
					nm = M_WORD;
				end else begin
					rv[1] = ent.cls.single_ok;
					rt[1] = '{ent.cls.single_kind, p, stl_pkg::pos_t'(1)};
				end
			end
		end

		// Flush whatever is pending at end of text.
		if (ent.eot) begin
			if (nm == M_HELD) begin
				ns    = stl_pkg::single_tok(nheld);
				rv[2] = ns[3];
				rt[2] = '{ns[2:0], ntb, stl_pkg::pos_t'(1)};
			end else if (nm != M_IDLE) begin
				rv[2] = 1'b1;
				rt[2] = '{mode_kind(nm), ntb, p - ntb + 1'b1};
			end
			nm   = M_IDLE;
			ntb  = '0;
			ndot = 1'b0;
		end
	end

	// Pack the valid results in order.
	always_comb begin
		n = '0;
		for (int i = 0; i < 3; i++) begin
			res[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			if (rv[i]) begin
				res[n] = rt[i];
				n      = n + 1'b1;
			end
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    cur = slot_q[0];
			2'd1:    cur = slot_q[1];
			2'd2:    cur = slot_q[2];
			default: cur = '0;
		endcase
	end

	assign empty        = idx_q == cnt_q;
	assign last         = 2'(idx_q + 2'd1) == cnt_q;
	assign load         = !qempty && (empty || (pop && last));
	assign qpop         = load;
	assign token_kind   = cur.kind;
	assign start_pos    = 20'(cur.start);
	assign token_length = 20'(cur.len);
	assign last_of_run  = last;
	assign pos_overflow = ovf_q;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 3; i++) begin
				slot_q[i] <= res[i];
			end
			ovf_q <= ent.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			tb_q   <= '0;
			dot_q  <= 1'b0;
			held_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (load) begin
			mode_q <= nm;
			tb_q   <= ntb;
			dot_q  <= ndot;
			held_q <= nheld;
			cnt_q  <= n;
			idx_q  <= '0;
		end else if (pop && !empty) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

FILE: rtl/sql_token_lexer_top.sv
// SQL token lexer top level: input classification, byte queue and token side.
//
// Takes SQL text one byte per clock while full is low and returns comment,
// literal, word, quoted identifier, operator and punctuation tokens as kind,
// start offset and length. A byte enters a four-entry queue through push/full;
// the token side takes one byte per clock from it as long as the results of
// the byte before are popped, and can deliver one result per clock through
// empty/pop. A byte that completes two or three tokens holds the token side
// until its results are popped, and the queue absorbs the input meanwhile. The
// first result of a byte shows on the result ports in the cycle after the token
// side takes the byte. Operators that may form a pair, and '-', '/', '.', ':'
// are held until the next byte arrives, so their token comes out with that byte.
module sql_token_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [19:0] start_pos,
	output logic [19:0] token_length,
	output logic        last_of_run,
	output logic        pos_overflow
);

	logic            wr_en;
	stl_pkg::entry_t wr_data;
	logic            rd_en;
	stl_pkg::entry_t rd_data;
	logic            qempty;

	stl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.char_byte   (char_byte),
		.end_of_text (end_of_text),
		.qfull       (full),
		.wr_en       (wr_en),
		.wr_data     (wr_data)
	);

	stl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.empty   (qempty)
	);

	stl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ent          (rd_data),
		.qempty       (qempty),
		.qpop         (rd_en),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.start_pos    (start_pos),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.pos_overflow (pos_overflow)
	);

endmodule
